// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL in this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check that is held off while the asynchronous reset is asserted.
`define ASSERT_CLK(label, clock, rst_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clock, prop, msg) \
	label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clock, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clock, prop, msg)

`endif

`endif

// File: sv/brb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

	// Default number of byte slots; one slot always stays empty.
	localparam int BRB_DEPTH = 128;

	// Width of the fill count on the result stream.
	localparam int FILL_W = 7;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_PEEK = 2'd1,
		OP_POP  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_BLOCK  = 2'd1,
		STAT_BADARG = 2'd2
	} status_t;

	// Everything of a result except the byte that the memory returns.
	typedef struct packed {
		status_t             status;
		logic                peek_ok;
		logic [FILL_W-1:0]   fill;
		logic                full;
		logic                empty;
	} brb_res_t;

endpackage

`default_nettype wire

// File: sv/byte_ring_buffer_peek_pop_top.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Byte ring buffer with push, peek at an offset, and multi-byte pop. The
// buffer has DEPTH slots (a power of two from 2 to 128) and, since one slot
// is always left empty, holds at most DEPTH-1 bytes. Each beat on the slave
// stream carries one operation selected by tuser: push appends a byte (would
// block when full), peek returns the byte a given offset past the oldest one
// (would block when the offset is at or past the fill count), and pop drops
// a given number of oldest bytes (bad argument when that exceeds the fill
// count; the unused opcode is also a bad argument). Every operation yields
// exactly one result beat carrying the status in tuser and the peeked byte,
// fill count, full and empty flags in tdata. The block takes one operation
// per clock cycle when the result stream is not stalled; a result passes
// through stage 1, alongside the registered read of the byte memory, and
// then the output register. Pointers are updated in the accept cycle, so
// a peek right after a push sees the new byte. The byte memory is not
// cleared after reset; a peek can only reach slots that were written
// earlier.
module byte_ring_buffer_peek_pop_top
	import brb_pkg::*;
#(
	parameter int DEPTH = BRB_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [7:0] data_byte, [15:8] offset_or_count
	input  wire logic [15:0] s_tdata,
	// [1:0] opcode
	input  wire logic [1:0]  s_tuser,

	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] read_byte, [14:8] fill_count, [15] is_full, [16] is_empty,
	// [23:17] zero
	output logic [23:0]      m_tdata,
	// [1:0] status
	output logic [1:0]       m_tuser
);

	localparam int PTR_W = $clog2(DEPTH);

	// Pointer state. The write pointer names the slot that the next push
	// fills, the read pointer names the oldest stored byte.
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_n;
	logic [PTR_W-1:0] rd_ptr_n;

	// Byte memory with a registered read port.
	logic [7:0]       mem_q [DEPTH];
	logic [7:0]       rd_data_q;
	logic             mem_we;
	logic             mem_re;
	logic [PTR_W-1:0] peek_addr;

	// Stage 1 holds the result of the operation while the memory read is
	// in progress; the output register follows it.
	logic             s1_valid_q;
	brb_res_t         s1_q;
	brb_res_t         res_n;
	logic             out_free;
	logic             in_fire;

	// Decode of the incoming beat.
	opcode_t          op;
	logic [7:0]       data_byte;
	logic [7:0]       arg;
	logic [PTR_W-1:0] fill_now;
	logic [PTR_W-1:0] fill_new;
	logic             full_now;
	status_t          status_n;

	assign op        = opcode_t'(s_tuser);
	assign data_byte = s_tdata[7:0];
	assign arg       = s_tdata[15:8];

	// The output register can take a new result when it is empty or its
	// current beat leaves this cycle. Stage 1 moves on under the same
	// condition, so a new beat is taken whenever stage 1 can empty.
	assign out_free = !m_tvalid || m_tready;
	assign s_tready = !s1_valid_q || out_free;
	assign in_fire  = s_tvalid && s_tready;

	assign fill_now  = wr_ptr_q - rd_ptr_q;
	assign full_now  = (wr_ptr_q + 1'b1) == rd_ptr_q;
	assign peek_addr = rd_ptr_q + arg[PTR_W-1:0];

	// Operation decode: status, pointer updates and memory accesses.
	always_comb begin
		status_n = STAT_OK;
		wr_ptr_n = wr_ptr_q;
		rd_ptr_n = rd_ptr_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		case (op)
			OP_PUSH: begin
				if (full_now) begin
					status_n = STAT_BLOCK;
				end else begin
					mem_we   = in_fire;
					wr_ptr_n = wr_ptr_q + 1'b1;
				end
			end
			OP_PEEK: begin
				if (arg >= 8'(fill_now)) begin
					status_n = STAT_BLOCK;
				end else begin
					mem_re = in_fire;
				end
			end
			OP_POP: begin
				if (arg > 8'(fill_now)) begin
					status_n = STAT_BADARG;
				end else begin
					rd_ptr_n = rd_ptr_q + arg[PTR_W-1:0];
				end
			end
			default: begin
				status_n = STAT_BADARG;
			end
		endcase
	end

	// Flags after the operation, taken from the updated pointers.
	assign fill_new = wr_ptr_n - rd_ptr_n;

	always_comb begin
		res_n.status  = status_n;
		res_n.peek_ok = (op == OP_PEEK) && (status_n == STAT_OK);
		res_n.fill    = FILL_W'(fill_new);
		res_n.full    = (wr_ptr_n + 1'b1) == rd_ptr_n;
		res_n.empty   = wr_ptr_n == rd_ptr_n;
	end

	// Byte memory: one write and one registered read per cycle. The read
	// register only loads on a peek, so it holds while stage 1 stalls.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_ptr_q] <= data_byte;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[peek_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else if (in_fire) begin
			wr_ptr_q <= wr_ptr_n;
			rd_ptr_q <= rd_ptr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			s1_q <= res_n;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_q) begin
			m_tuser         <= s1_q.status;
			m_tdata[7:0]    <= s1_q.peek_ok ? rd_data_q : 8'd0;
			m_tdata[14:8]   <= s1_q.fill;
			m_tdata[15]     <= s1_q.full;
			m_tdata[16]     <= s1_q.empty;
			m_tdata[23:17]  <= '0;
		end
	end

	// A successful push advances the write pointer by exactly one slot.
	`ASSERT_CLK(a_push_advances, clk, arst_n, in_fire && mem_we |=> wr_ptr_q == PTR_W'($past(wr_ptr_q) + 1'b1), "push did not advance the write pointer")

	// Only pushes move the write pointer.
	`ASSERT_CLK(a_wr_only_on_push, clk, arst_n, !(in_fire && mem_we) |=> $stable(wr_ptr_q), "write pointer moved without a push")

	// A stalled stage 1 keeps its result and its memory read data.
	`ASSERT_CLK(a_s1_holds, clk, arst_n, s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_q) && $stable(rd_data_q), "stage 1 lost its result while stalled")

	// The buffer is never reported full and empty at once.
	`ASSERT_CLK(a_flags_exclusive, clk, arst_n, s1_valid_q |-> !(s1_q.full && s1_q.empty), "full and empty both set")

	// Nothing is in flight right after reset.
	`ASSERT_ALWAYS(a_reset_clear, clk, !arst_n |=> !s1_valid_q && !m_tvalid, "pipeline not empty after reset")

endmodule

`default_nettype wire

// File: dv/byte_ring_buffer_peek_pop_top_tb.sv
`timescale 1ns / 1ps

module byte_ring_buffer_peek_pop_top_tb;
	import brb_pkg::*;

	localparam int DEPTH = BRB_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int MAX_PRINTED = 40;

	// The one opcode value that the package leaves without a name.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// One expected result beat, field by field.
	typedef struct packed {
		status_t           status;
		logic [7:0]        peeked;
		logic [FILL_W-1:0] fill;
		logic              full;
		logic              empty;
	} ring_result_t;

	// Clock, reset and every input start at a known value.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [7:0] data_byte, [15:8] offset_or_count
	logic [15:0] s_tdata = '0;
	// [1:0] opcode
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [7:0] read_byte, [14:8] fill_count, [15] is_full, [16] is_empty, [23:17] zero
	logic [23:0] m_tdata;
	// [1:0] status
	logic [1:0]  m_tuser;

	// Shadow copy of the buffer, advanced once per accepted operation.
	logic [7:0]       shadow_bytes [DEPTH];
	logic [PTR_W-1:0] shadow_wr = '0;
	logic [PTR_W-1:0] shadow_rd = '0;
	ring_result_t     pending_results [$];

	int  error_count = 0;
	int  cycle_count = 0;
	int  stall_left = 0;
	bit  idle_en = 1'b1;
	bit  draining = 1'b0;

	byte_ring_buffer_peek_pop_top #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic int stored_count();
		logic [PTR_W-1:0] diff;
		diff = shadow_wr - shadow_rd;
		return int'(diff);
	endfunction

	// Applies one operation to the shadow buffer and returns the result beat that the
	// block should send for it. The pointers wrap naturally at the pointer width.
	function automatic ring_result_t ring_apply(logic [1:0] op, logic [7:0] data,
			logic [7:0] arg);
		ring_result_t     res;
		logic [PTR_W-1:0] level;
		res = '0;
		res.status = STAT_OK;
		level = shadow_wr - shadow_rd;
		case (op)
			OP_PUSH: begin
				if (int'(level) == DEPTH - 1) begin
					res.status = STAT_BLOCK;
				end else begin
					shadow_bytes[shadow_wr] = data;
					shadow_wr = shadow_wr + 1'b1;
				end
			end
			OP_PEEK: begin
				if (int'(arg) >= int'(level)) begin
					res.status = STAT_BLOCK;
				end else begin
					res.peeked = shadow_bytes[PTR_W'(shadow_rd + arg[PTR_W-1:0])];
				end
			end
			OP_POP: begin
				if (int'(arg) > int'(level)) begin
					res.status = STAT_BADARG;
				end else begin
					shadow_rd = shadow_rd + arg[PTR_W-1:0];
				end
			end
			default: begin
				res.status = STAT_BADARG;
			end
		endcase
		level = shadow_wr - shadow_rd;
		res.fill = FILL_W'(level);
		res.full = (int'(level) == DEPTH - 1);
		res.empty = (shadow_wr == shadow_rd);
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= MAX_PRINTED) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
	endtask

	// Presents one operation and holds it until the block takes the beat. Valid stays
	// high after acceptance so that back-to-back beats never toggle it within a step;
	// it only drops when an idle burst begins or when the run ends.
	task automatic send_op(logic [1:0] op, logic [7:0] data, logic [7:0] arg);
		if (idle_en && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {arg, data};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(ring_apply(op, data, arg));
	endtask

	// One random operation. Most traffic is legal and follows a fill or drain trend so
	// that the buffer swings between empty and full; a small share is out of range or
	// uses the unused opcode.
	task automatic random_item();
		int         level;
		int         pick;
		logic [1:0] op;
		logic [7:0] data;
		logic [7:0] arg;
		level = stored_count();
		if (level == DEPTH - 1) begin
			draining = 1'b1;
		end else if (level == 0) begin
			draining = 1'b0;
		end else if ($urandom_range(0, 99) == 0) begin
			draining = ~draining;
		end
		pick = $urandom_range(0, 99);
		data = 8'($urandom_range(0, 255));
		arg = 8'($urandom_range(0, 255));
		if (pick < 5) begin
			case ($urandom_range(0, 2))
				0: op = OP_UNUSED;
				1: begin
					op = OP_PEEK;
					arg = 8'($urandom_range(level, 255));
				end
				default: begin
					op = OP_POP;
					arg = 8'($urandom_range(level + 1, 255));
				end
			endcase
		end else if (pick < (draining ? 20 : 65)) begin
			op = OP_PUSH;
		end else if (pick < (draining ? 45 : 88)) begin
			op = OP_PEEK;
			if (level > 0) begin
				arg = 8'($urandom_range(0, level - 1));
			end
		end else begin
			op = OP_POP;
			if (draining) begin
				arg = 8'($urandom_range(0, (level < 8) ? level : 8));
				if ($urandom_range(0, 19) == 0) begin
					arg = 8'(level);
				end
			end else begin
				arg = 8'($urandom_range(0, (level < 2) ? level : 2));
			end
		end
		send_op(op, data, arg);
	endtask

	// Boundary cases on a nearly empty buffer: every operation, the unused opcode,
	// peeks and pops at and beyond the fill count, and a pop of zero bytes.
	task automatic test_directed_corners();
		send_op(OP_PEEK, 8'h00, 8'h00);
		send_op(OP_POP, 8'h00, 8'h00);
		send_op(OP_POP, 8'h00, 8'h01);
		send_op(OP_POP, 8'hFF, 8'hFF);
		send_op(OP_UNUSED, 8'hFF, 8'hFF);
		send_op(OP_UNUSED, 8'h00, 8'h00);
		send_op(OP_PUSH, 8'h00, 8'hFF);
		send_op(OP_PUSH, 8'hFF, 8'h00);
		send_op(OP_PUSH, 8'hA5, 8'h5A);
		send_op(OP_PEEK, 8'hFF, 8'h00);
		send_op(OP_PEEK, 8'h00, 8'h01);
		send_op(OP_PEEK, 8'h00, 8'h02);
		send_op(OP_PEEK, 8'h00, 8'h03);
		send_op(OP_PEEK, 8'h00, 8'hFF);
		send_op(OP_POP, 8'h00, 8'h00);
		send_op(OP_POP, 8'h00, 8'h04);
		send_op(OP_POP, 8'h00, 8'h02);
		send_op(OP_PEEK, 8'h00, 8'h00);
		send_op(OP_POP, 8'h00, 8'h01);
		send_op(OP_PUSH, 8'h5A, 8'h80);
		send_op(OP_PEEK, 8'h00, 8'h00);
		send_op(OP_POP, 8'h00, 8'h01);
	endtask

	// Fills the buffer to its last free slot, probes the full boundary, and then runs
	// two more laps so that both pointers wrap while data is in flight.
	task automatic test_full_and_wrap();
		int chunk;
		while (stored_count() < DEPTH - 1) begin
			send_op(OP_PUSH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		end
		send_op(OP_PUSH, 8'hC3, 8'h00);
		send_op(OP_PUSH, 8'h3C, 8'hFF);
		send_op(OP_PEEK, 8'h00, 8'(DEPTH - 2));
		send_op(OP_PEEK, 8'h00, 8'(DEPTH - 1));
		send_op(OP_PEEK, 8'h00, 8'hFF);
		send_op(OP_POP, 8'h00, 8'(DEPTH));
		send_op(OP_POP, 8'h00, 8'(DEPTH - 1));
		repeat (2) begin
			while (stored_count() < DEPTH - 1) begin
				send_op(OP_PUSH, 8'($urandom_range(0, 255)), 8'h00);
			end
			while (stored_count() > 0) begin
				chunk = $urandom_range(1, 16);
				if (chunk > stored_count()) begin
					chunk = stored_count();
				end
				send_op(OP_PEEK, 8'h00, 8'($urandom_range(0, stored_count() - 1)));
				send_op(OP_POP, 8'h00, 8'(chunk));
			end
		end
	endtask

	task automatic test_random_traffic(int count);
		repeat (count) random_item();
	endtask

	// Same mix with both sides always ready, so beats go through at full rate.
	task automatic test_full_rate(int count);
		idle_en = 1'b0;
		repeat (count) random_item();
	endtask

	// The result side stalls in bursts while idling is enabled; a burst that is still
	// running when idling ends is cut short.
	always @(posedge clk) begin
		if (idle_en && stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 11) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Each result beat is matched against the oldest expectation, field by field.
	always @(posedge clk) begin
		ring_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat tdata=%h tuser=%h",
					m_tdata, m_tuser));
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status) begin
					report_mismatch($sformatf("status %0d, expected %0d",
						m_tuser, want.status));
				end
				if (m_tdata[7:0] !== want.peeked) begin
					report_mismatch($sformatf("read_byte %h, expected %h",
						m_tdata[7:0], want.peeked));
				end
				if (m_tdata[14:8] !== want.fill) begin
					report_mismatch($sformatf("fill_count %0d, expected %0d",
						m_tdata[14:8], want.fill));
				end
				if (m_tdata[15] !== want.full) begin
					report_mismatch($sformatf("is_full %b, expected %b",
						m_tdata[15], want.full));
				end
				if (m_tdata[16] !== want.empty) begin
					report_mismatch($sformatf("is_empty %b, expected %b",
						m_tdata[16], want.empty));
				end
				if (m_tdata[23:17] !== '0) begin
					report_mismatch($sformatf("padding bits %h are not zero",
						m_tdata[23:17]));
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("byte_ring_buffer_peek_pop_top verification failed");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_corners();
		test_full_and_wrap();
		test_random_traffic(1300);
		test_full_rate(200);

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		end
		if (error_count == 0) begin
			$display("byte_ring_buffer_peek_pop_top verification clean");
		end else begin
			$display("byte_ring_buffer_peek_pop_top verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/brb_pkg.sv
sv/byte_ring_buffer_peek_pop_top.sv
dv/byte_ring_buffer_peek_pop_top_tb.sv
